### sv/ping_pong_sample_capture_playback_defines.svh
// Assertion macros for the checker of the capture/playback block.
`ifndef PING_PONG_SAMPLE_CAPTURE_PLAYBACK_DEFINES_SVH
`define PING_PONG_SAMPLE_CAPTURE_PLAYBACK_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PPSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PPSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ppsc_pkg.sv
package ppsc_pkg;

  // Buffer geometry: two blocks of BLOCK_LENGTH bytes in one memory.
  localparam int BLOCK_LENGTH = 512;
  localparam int POS_W = $clog2(BLOCK_LENGTH);
  localparam int ADDR_W = POS_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int BYTE_W = 8;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Request codes carried by each input word.
  typedef enum logic [3:0] {
    REQ_TICK       = 4'd0,
    REQ_CAP_START  = 4'd1,
    REQ_CAP_STOP   = 4'd2,
    REQ_PLAY_START = 4'd3,
    REQ_PLAY_STOP  = 4'd4,
    REQ_WRITE      = 4'd5,
    REQ_READ       = 4'd6,
    REQ_MARK_FULL  = 4'd7,
    REQ_MARK_EMPTY = 4'd8
  } req_t;

  // Controller modes, reported as the controller state.
  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_PLAY_WAIT = 3'd1,
    MODE_PLAYBACK  = 3'd2,
    MODE_CAP_WAIT  = 3'd3,
    MODE_CAPTURE   = 3'd4
  } mode_t;

  // One access to the sample memory.
  typedef struct packed {
    logic  en;
    logic  we;
    addr_t addr;
    byte_t wdata;
  } mem_req_t;

  // Status reported with every result word.
  typedef struct packed {
    logic  buffer0_full;
    logic  buffer1_full;
    logic  capturing;
    logic  playing;
    mode_t mode;
  } status_t;

  // What the result stage needs besides the memory read data.
  typedef struct packed {
    logic    duty_load;
    logic    read_ok;
    status_t status;
  } result_meta_t;

endpackage

### sv/ppsc_ram.sv
// Single-port synchronous RAM with a registered read.
module ppsc_ram #(
  parameter int DataW = 8,
  parameter int Depth = 1024,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AddrW-1:0] addr,
  input  logic [DataW-1:0] wdata,
  output logic [DataW-1:0] rdata
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_r;

  // Write on enable, otherwise register the addressed entry.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/ppsc_ctrl.sv
// Controller: mode, block position, buffer flags and pending requests.
// Every accepted word may update the state and issues at most one memory access.
module ppsc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept_i,
  input  logic [3:0]              req_i,
  input  logic                    sel_i,
  input  logic [8:0]              idx_i,
  input  ppsc_pkg::byte_t         data_i,
  output ppsc_pkg::mem_req_t      mem_req_o,
  output ppsc_pkg::result_meta_t  meta_o
);

  ppsc_pkg::mode_t mode_r, mode_nxt;
  ppsc_pkg::pos_t  pos_r, pos_nxt;
  logic            act_r, act_nxt;
  logic [1:0]      full_r, full_nxt;
  logic            cap_start_r, cap_start_nxt;
  logic            cap_stop_r, cap_stop_nxt;
  logic            play_req_r, play_req_nxt;
  logic            play_stop_r, play_stop_nxt;
  logic            cap_act_r, cap_act_nxt;

  logic            idx_ok;
  logic            pos_last;
  ppsc_pkg::addr_t work_addr;
  ppsc_pkg::addr_t host_addr;

  assign idx_ok    = int'(idx_i) < ppsc_pkg::BLOCK_LENGTH;
  assign pos_last  = pos_r == ppsc_pkg::pos_t'(ppsc_pkg::BLOCK_LENGTH - 1);
  assign work_addr = {act_r, pos_r};
  assign host_addr = {sel_i, ppsc_pkg::pos_t'(idx_i)};

  // Next state, memory access and result flags for the accepted word.
  always_comb begin
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    act_nxt       = act_r;
    full_nxt      = full_r;
    cap_start_nxt = cap_start_r;
    cap_stop_nxt  = cap_stop_r;
    play_req_nxt  = play_req_r;
    play_stop_nxt = play_stop_r;
    cap_act_nxt   = cap_act_r;
    mem_req_o     = '0;
    meta_o        = '0;

    if (accept_i) begin
      unique case (ppsc_pkg::req_t'(req_i))
        ppsc_pkg::REQ_TICK: begin
          unique case (mode_r)
            ppsc_pkg::MODE_IDLE: begin
              if (cap_start_r) begin
                cap_act_nxt   = 1'b1;
                cap_stop_nxt  = 1'b0;
                cap_start_nxt = 1'b0;
                mode_nxt      = ppsc_pkg::MODE_CAPTURE;
                pos_nxt       = '0;
                act_nxt       = 1'b0;
              end else if (play_req_r) begin
                play_stop_nxt = 1'b0;
                mode_nxt      = ppsc_pkg::MODE_PLAYBACK;
                pos_nxt       = '0;
                act_nxt       = 1'b0;
              end
            end
            ppsc_pkg::MODE_PLAY_WAIT, ppsc_pkg::MODE_PLAYBACK: begin
              if (mode_r == ppsc_pkg::MODE_PLAYBACK || full_r[act_r]) begin
                // Emit the next stored byte.
                mem_req_o.en     = 1'b1;
                mem_req_o.addr   = work_addr;
                meta_o.duty_load = 1'b1;
                mode_nxt         = ppsc_pkg::MODE_PLAYBACK;
                pos_nxt          = pos_r + ppsc_pkg::pos_t'(1);
                if (pos_last) begin
                  // Block end: drain this buffer and move to the other one.
                  full_nxt[act_r] = 1'b0;
                  act_nxt         = ~act_r;
                  pos_nxt         = '0;
                  if (!full_r[~act_r]) begin
                    mode_nxt = ppsc_pkg::MODE_PLAY_WAIT;
                  end
                  if (play_stop_r) begin
                    play_stop_nxt = 1'b0;
                    play_req_nxt  = 1'b0;
                    mode_nxt      = ppsc_pkg::MODE_IDLE;
                  end
                end
              end
            end
            ppsc_pkg::MODE_CAP_WAIT, ppsc_pkg::MODE_CAPTURE: begin
              if (mode_r == ppsc_pkg::MODE_CAPTURE || !full_r[act_r]) begin
                // Store the microphone byte.
                mem_req_o.en    = 1'b1;
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = work_addr;
                mem_req_o.wdata = data_i;
                mode_nxt        = ppsc_pkg::MODE_CAPTURE;
                pos_nxt         = pos_r + ppsc_pkg::pos_t'(1);
                if (pos_last) begin
                  // Block end: mark this buffer full and move to the other one.
                  full_nxt[act_r] = 1'b1;
                  act_nxt         = ~act_r;
                  pos_nxt         = '0;
                  if (full_r[~act_r]) begin
                    mode_nxt = ppsc_pkg::MODE_CAP_WAIT;
                  end
                  if (cap_stop_r) begin
                    cap_stop_nxt = 1'b0;
                    cap_act_nxt  = 1'b0;
                    mode_nxt     = ppsc_pkg::MODE_IDLE;
                  end
                end
              end
            end
            default: begin
              mode_nxt = ppsc_pkg::MODE_IDLE;
            end
          endcase
        end
        ppsc_pkg::REQ_CAP_START: cap_start_nxt = 1'b1;
        ppsc_pkg::REQ_CAP_STOP: cap_stop_nxt = 1'b1;
        ppsc_pkg::REQ_PLAY_START: play_req_nxt = 1'b1;
        ppsc_pkg::REQ_PLAY_STOP: play_stop_nxt = 1'b1;
        ppsc_pkg::REQ_WRITE: begin
          mem_req_o.en    = idx_ok;
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = host_addr;
          mem_req_o.wdata = data_i;
        end
        ppsc_pkg::REQ_READ: begin
          mem_req_o.en   = idx_ok;
          mem_req_o.addr = host_addr;
          meta_o.read_ok = idx_ok;
        end
        ppsc_pkg::REQ_MARK_FULL: full_nxt[sel_i] = 1'b1;
        ppsc_pkg::REQ_MARK_EMPTY: full_nxt[sel_i] = 1'b0;
        default: begin
        end
      endcase
    end

    meta_o.status.buffer0_full = full_nxt[0];
    meta_o.status.buffer1_full = full_nxt[1];
    meta_o.status.capturing    = cap_act_nxt;
    meta_o.status.playing      = play_req_nxt;
    meta_o.status.mode         = mode_nxt;
  end

  // Control state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= ppsc_pkg::MODE_IDLE;
      pos_r       <= '0;
      act_r       <= 1'b0;
      full_r      <= '0;
      cap_start_r <= 1'b0;
      cap_stop_r  <= 1'b0;
      play_req_r  <= 1'b0;
      play_stop_r <= 1'b0;
      cap_act_r   <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      act_r       <= act_nxt;
      full_r      <= full_nxt;
      cap_start_r <= cap_start_nxt;
      cap_stop_r  <= cap_stop_nxt;
      play_req_r  <= play_req_nxt;
      play_stop_r <= play_stop_nxt;
      cap_act_r   <= cap_act_nxt;
    end
  end

endmodule

### sv/ping_pong_sample_capture_playback.sv
// An accepted word is held in the read stage, then in the output register.
// Throughput: one word per cycle unless stalled; each word makes at most one
// access to the single-port sample memory, so the memory port sets the rate.
// Reset (synchronous, rst_n low): idle mode, both buffers empty, no requests
// pending, pipeline empty. Sample memory contents are not cleared.
module ping_pong_sample_capture_playback (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [3:0]             in_req_type,
  input  logic                   in_buffer_sel,
  input  logic [8:0]             in_byte_index,
  input  logic [7:0]             in_data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_duty_value,
  output logic                   out_duty_load,
  output logic [7:0]             out_read_byte,
  output logic                   out_buffer0_full,
  output logic                   out_buffer1_full,
  output logic                   out_capturing,
  output logic                   out_playing,
  output logic [2:0]             out_controller_state
);

  logic                   accept;
  ppsc_pkg::mem_req_t     mem_req;
  ppsc_pkg::result_meta_t meta;
  ppsc_pkg::byte_t        rdata;

  logic                   p1_valid_r, p1_valid_nxt;
  ppsc_pkg::result_meta_t p1_meta_r;
  logic                   p1_adv;

  logic                   out_valid_r, out_valid_nxt;
  ppsc_pkg::byte_t        duty_r;
  logic                   duty_load_r;
  ppsc_pkg::byte_t        read_byte_r;
  ppsc_pkg::status_t      status_r;

  // The read stage moves on whenever the output register is free.
  assign p1_adv   = p1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = p1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  ppsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept_i  (accept),
    .req_i     (in_req_type),
    .sel_i     (in_buffer_sel),
    .idx_i     (in_byte_index),
    .data_i    (in_data_byte),
    .mem_req_o (mem_req),
    .meta_o    (meta)
  );

  ppsc_ram #(
    .DataW (ppsc_pkg::BYTE_W),
    .Depth (ppsc_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_req.en),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // Valid bits for the read stage and the output register.
  always_comb begin
    p1_valid_nxt  = accept || (p1_valid_r && !p1_adv);
    out_valid_nxt = p1_adv || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Read stage word description; the memory holds its read data meanwhile.
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_meta_r <= meta;
    end
  end

  // Output register, filled from the read stage.
  always_ff @(posedge clk) begin
    if (p1_adv) begin
      duty_r      <= p1_meta_r.duty_load ? rdata : '0;
      duty_load_r <= p1_meta_r.duty_load;
      read_byte_r <= p1_meta_r.read_ok ? rdata : '0;
      status_r    <= p1_meta_r.status;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_duty_value       = duty_r;
  assign out_duty_load        = duty_load_r;
  assign out_read_byte        = read_byte_r;
  assign out_buffer0_full     = status_r.buffer0_full;
  assign out_buffer1_full     = status_r.buffer1_full;
  assign out_capturing        = status_r.capturing;
  assign out_playing          = status_r.playing;
  assign out_controller_state = status_r.mode;

endmodule

### sv/ppsc_checker.sv
`include "ping_pong_sample_capture_playback_defines.svh"

// Port-level checks on the capture/playback block.
module ppsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_duty_value,
  input logic       out_duty_load,
  input logic [7:0] out_read_byte,
  input logic       out_buffer0_full,
  input logic       out_buffer1_full,
  input logic       out_capturing,
  input logic       out_playing,
  input logic [2:0] out_controller_state
);

  logic        play_mode;
  logic        cap_mode;
  logic        idle_mode;
  logic [23:0] out_word;

  // Mode classes shown on the result word, and the whole word for the hold check.
  assign play_mode = (out_controller_state == ppsc_pkg::MODE_PLAYBACK) ||
                     (out_controller_state == ppsc_pkg::MODE_PLAY_WAIT);
  assign cap_mode  = (out_controller_state == ppsc_pkg::MODE_CAPTURE) ||
                     (out_controller_state == ppsc_pkg::MODE_CAP_WAIT);
  assign idle_mode = out_controller_state == ppsc_pkg::MODE_IDLE;
  assign out_word  = {out_duty_value, out_duty_load, out_read_byte, out_buffer0_full,
                      out_buffer1_full, out_capturing, out_playing, out_controller_state};

  // A word without a playback byte carries a zero duty value.
  `PPSC_ASSERT_IMP(a_duty_zero, out_valid && !out_duty_load, out_duty_value == 8'd0, "duty value without load")

  // After emitting a byte the controller is in a playback mode or back in idle.
  `PPSC_ASSERT_IMP(a_duty_mode, out_valid && out_duty_load, play_mode || idle_mode, "duty byte outside playback")

  // Capture modes require an active capture session.
  `PPSC_ASSERT_IMP(a_cap_mode, out_valid && !out_capturing, !cap_mode, "capture mode without session")

  // Playback modes require a standing play request.
  `PPSC_ASSERT_IMP(a_play_mode, out_valid && !out_playing, !play_mode, "playback mode without request")

  // A stalled result word stays put.
  `PPSC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled result changed")

endmodule

bind ping_pong_sample_capture_playback ppsc_checker u_ppsc_checker (.*);
